>>> design/bgc_pkg.sv
// Shared types and constants for the button gesture classifier.
// No dependencies; compiled first.
package bgc_pkg;

    localparam int unsigned BUTTON_W  = 2;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned MASK_W    = 3;
    localparam int unsigned APB_W     = 32;
    localparam int unsigned PADDR_W   = 4;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_LONG   = 2'd1,
        KIND_DOUBLE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        REG_LONG_PRESS = 2'd0,
        REG_DOUBLE_TAP = 2'd1,
        REG_ENABLE     = 2'd2
    } reg_index_t;

    localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 16'd2000;
    localparam logic [LIMIT_W-1:0] DOUBLE_TAP_RESET = 16'd400;
    localparam logic [MASK_W-1:0]  ENABLE_RESET     = 3'b111;

endpackage

>>> design/bgc_sample_if.sv
// Request channel carrying one polled button sample.
// Depends on bgc_pkg for field widths.
interface bgc_sample_if
    import bgc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [BUTTON_W-1:0] button_index;
    logic                pressed;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, button_index, pressed, now_ms, input ready);
    modport sink   (input valid, button_index, pressed, now_ms, output ready);
endinterface

>>> design/bgc_event_if.sv
// Request channel carrying one classified gesture event.
// Depends on bgc_pkg for field widths.
interface bgc_event_if
    import bgc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [BUTTON_W-1:0] event_button;
    logic [1:0]          event_kind;

    modport source (output valid, event_button, event_kind, input ready);
    modport sink   (input valid, event_button, event_kind, output ready);
endinterface

>>> design/button_gesture_classifier.sv
// Top level of the button gesture classifier.
// Depends on bgc_pkg, bgc_sample_if and bgc_event_if.
//
// Usage:
//   samples: one request per polled button sample (button_index, pressed,
//            now_ms). Taken at a clock edge with valid and ready high.
//   events : zero or one request per sample (event_button, event_kind).
//   APB    : long_press_ms at 0x0, double_tap_ms at 0x4, enable_mask at 0x8.
//            Write only while no sample is in flight; pready is tied high.
// Pipeline: a sample is registered in the input register, classified there
//   against the per-button state, and its event is registered in the result
//   register, from which events.valid is driven until the event is taken.
// Throughput: one sample per cycle unless stalled; state is read and written
//   back in the same cycle: consecutive samples of one button need no bubble.
// Reset: all button state clears, registers take 2000 / 400 / 0b111.
// Stall: while the event register is full and not taken, the input register
//   holds and ready drops once it is occupied too; nothing is lost.
module button_gesture_classifier
    import bgc_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    bgc_sample_if.sink          samples,
    bgc_event_if.source         events,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    localparam int unsigned ACTIVE = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;

    logic [LIMIT_W-1:0]  long_press_reg;
    logic [LIMIT_W-1:0]  double_tap_reg;
    logic [MASK_W-1:0]   enable_reg;

    logic                s1_valid_reg;
    logic [BUTTON_W-1:0] s1_button_reg;
    logic                s1_pressed_reg;
    logic [TIME_W-1:0]   s1_now_reg;

    logic                out_valid_reg;
    logic [BUTTON_W-1:0] out_button_reg;
    event_kind_t         out_kind_reg;

    logic [ACTIVE-1:0]   held_reg;
    logic [ACTIVE-1:0]   ignoring_reg;
    logic [TIME_W-1:0]   press_start_reg [ACTIVE];
    logic [TIME_W-1:0]   last_tap_reg    [ACTIVE];

    logic [ACTIVE-1:0]   hit;
    logic                sel_held;
    logic                sel_ignoring;
    logic [TIME_W-1:0]   sel_press_start;
    logic [TIME_W-1:0]   sel_last_tap;
    logic                held_next;
    logic                ignoring_next;
    logic [TIME_W-1:0]   press_start_next;
    logic [TIME_W-1:0]   last_tap_next;
    logic                fire;
    event_kind_t         kind;
    logic [TIME_W-1:0]   press_elapsed;
    logic [TIME_W-1:0]   tap_elapsed;
    logic [TIME_W-1:0]   long_limit;
    logic [TIME_W-1:0]   tap_limit;
    logic                advance;
    logic                cfg_write;
    reg_index_t          cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RESET;
            double_tap_reg <= DOUBLE_TAP_RESET;
            enable_reg     <= ENABLE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LONG_PRESS: long_press_reg <= pwdata[LIMIT_W-1:0];
                REG_DOUBLE_TAP: double_tap_reg <= pwdata[LIMIT_W-1:0];
                REG_ENABLE:     enable_reg     <= pwdata[MASK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_LONG_PRESS: prdata = {{(APB_W-LIMIT_W){1'b0}}, long_press_reg};
            REG_DOUBLE_TAP: prdata = {{(APB_W-LIMIT_W){1'b0}}, double_tap_reg};
            REG_ENABLE:     prdata = {{(APB_W-MASK_W){1'b0}}, enable_reg};
            default:        prdata = '0;
        endcase
    end

    assign advance       = s1_valid_reg && (!out_valid_reg || events.ready);
    assign samples.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_button_reg  <= samples.button_index;
            s1_pressed_reg <= samples.pressed;
            s1_now_reg     <= samples.now_ms;
        end
    end

    always_comb
    begin
        hit             = '0;
        sel_held        = 1'b0;
        sel_ignoring    = 1'b0;
        sel_press_start = '0;
        sel_last_tap    = '0;
        for (int i = 0; i < ACTIVE; i++)
        begin
            hit[i] = (s1_button_reg == BUTTON_W'(i)) && enable_reg[i];
            if (hit[i])
            begin
                sel_held        = held_reg[i];
                sel_ignoring    = ignoring_reg[i];
                sel_press_start = press_start_reg[i];
                sel_last_tap    = last_tap_reg[i];
            end
        end
    end

    assign press_elapsed = s1_now_reg - sel_press_start;
    assign tap_elapsed   = s1_now_reg - sel_last_tap;
    assign long_limit    = {{(TIME_W-LIMIT_W){1'b0}}, long_press_reg};
    assign tap_limit     = {{(TIME_W-LIMIT_W){1'b0}}, double_tap_reg};

    always_comb
    begin
        held_next        = sel_held;
        ignoring_next    = sel_ignoring;
        press_start_next = sel_press_start;
        last_tap_next    = sel_last_tap;
        fire             = 1'b0;
        kind             = KIND_SHORT;
        if (s1_pressed_reg)
        begin
            if (!sel_held)
            begin
                held_next        = 1'b1;
                ignoring_next    = 1'b0;
                press_start_next = s1_now_reg;
            end
            else if (!sel_ignoring && (press_elapsed > long_limit))
            begin
                fire          = 1'b1;
                kind          = KIND_LONG;
                ignoring_next = 1'b1;
            end
        end
        else if (sel_held)
        begin
            held_next = 1'b0;
            if (!sel_ignoring)
            begin
                if ((sel_last_tap != '0) && (tap_elapsed < tap_limit))
                begin
                    last_tap_next = '0;
                    fire          = 1'b1;
                    kind          = KIND_DOUBLE;
                end
                else
                begin
                    last_tap_next = s1_now_reg;
                end
            end
        end
        else if ((sel_last_tap != '0) && (tap_elapsed > tap_limit))
        begin
            last_tap_next = '0;
            fire          = 1'b1;
            kind          = KIND_SHORT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            ignoring_reg <= '0;
            for (int i = 0; i < ACTIVE; i++)
            begin
                press_start_reg[i] <= '0;
                last_tap_reg[i]    <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                if (hit[i])
                begin
                    held_reg[i]        <= held_next;
                    ignoring_reg[i]    <= ignoring_next;
                    press_start_reg[i] <= press_start_next;
                    last_tap_reg[i]    <= last_tap_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= (|hit) && fire;
        end
        else if (events.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_button_reg <= s1_button_reg;
            out_kind_reg   <= kind;
        end
    end

    assign events.valid        = out_valid_reg;
    assign events.event_button = out_button_reg;
    assign events.event_kind   = out_kind_reg;

endmodule
